// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the tree store RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RRT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rrtnv_pkg.sv
// ----------------------------------------------------------------------------
// rrtnv_pkg
// Types and constants of the tree store: beat layouts, commands, status codes,
// configuration register indexes and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrtnv_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned IDX_W      = 13;
  localparam int unsigned STS_W      = 2;
  localparam int unsigned DSQ_W      = 25;
  localparam int unsigned RAD_W      = 13;
  localparam int unsigned RSQ_W      = 2 * RAD_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [RAD_W-1:0] GOAL_RADIUS_RST = RAD_W'(8);

  typedef enum logic [CMD_W-1:0] {
    CMD_ROOT    = 2'd0,
    CMD_NEAREST = 2'd1,
    CMD_ADD     = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_UNWRITTEN = 2'd2,
    STS_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GOAL_X      = 2'd0,
    CFG_GOAL_Y      = 2'd1,
    CFG_GOAL_RADIUS = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [IDX_W-1:0] vertex_index;
  } in_item_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [IDX_W-1:0] result_index;
    logic [POS_W-1:0] vertex_x;
    logic [POS_W-1:0] vertex_y;
    logic [IDX_W-1:0] parent_index;
    logic             has_parent;
    logic [DSQ_W-1:0] distance_sq;
    logic             goal_reached;
  } out_item_t;

endpackage

// File: hw/rtl/rrtnv_store.sv
// ----------------------------------------------------------------------------
// rrtnv_store
// Vertex memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrtnv_store #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13,
  parameter int unsigned DW    = 37
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/rrtnv_dist.sv
// ----------------------------------------------------------------------------
// rrtnv_dist
// Three-stage squared distance: absolute differences, squares, sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrtnv_dist #(
  parameter int unsigned CW = 12
) (
  input  logic            clk_i,
  input  logic [CW-1:0]   a_x_i,
  input  logic [CW-1:0]   a_y_i,
  input  logic [CW-1:0]   b_x_i,
  input  logic [CW-1:0]   b_y_i,
  output logic [2*CW:0]   dist_sq_o
);

  logic [CW-1:0]   adx_d, ady_d;
  logic [CW-1:0]   adx_q, ady_q;
  logic [2*CW-1:0] sqx_q, sqy_q;
  logic [2*CW:0]   sum_q;

  assign adx_d = (a_x_i > b_x_i) ? (a_x_i - b_x_i) : (b_x_i - a_x_i);
  assign ady_d = (a_y_i > b_y_i) ? (a_y_i - b_y_i) : (b_y_i - a_y_i);

  always_ff @(posedge clk_i) begin
    adx_q <= adx_d;
    ady_q <= ady_d;
    sqx_q <= (2*CW)'(adx_q) * (2*CW)'(adx_q);
    sqy_q <= (2*CW)'(ady_q) * (2*CW)'(ady_q);
    sum_q <= (2*CW+1)'(sqx_q) + (2*CW+1)'(sqy_q);
  end

  assign dist_sq_o = sum_q;

endmodule

// File: hw/rtl/rrt_tree_nearest_vertex.sv
// ----------------------------------------------------------------------------
// rrt_tree_nearest_vertex
// Root, add and read answers pass through the entry pipeline; nearest answers
// first scan every stored vertex; error answers skip the pipeline.
// Throughput: one item at a time; the nearest scan reads one vertex per cycle
// from the vertex memory port. The next beat is taken once the result is in
// the output register. Reset empties the tree and sets goal radius to 8.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrt_tree_nearest_vertex
  import rrtnv_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 8192,
  parameter int unsigned COORD_BITS   = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned DW    = 2 * CW + 1;
  localparam int unsigned GW    = (DW > RSQ_W) ? DW : RSQ_W;
  localparam int unsigned MW    = 2 * CW + IDX_W;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             direct;
    logic [AW-1:0]    idx;
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [IDX_W-1:0] parent;
  } iss_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [AW-1:0]    idx;
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [IDX_W-1:0] parent;
  } ent_t;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [AW-1:0]    scan_ptr_q, scan_ptr_d;
  logic [CW-1:0]    q_x_q, q_x_d, q_y_q, q_y_d;
  status_e          sts_q, sts_d;
  logic             dist_en_q, dist_en_d;

  logic [CW-1:0]    goal_x_q, goal_y_q;
  logic [RAD_W-1:0] goal_radius_q;
  logic [RSQ_W-1:0] r_sq_q;

  iss_t             iss;
  iss_t             s1_q;
  ent_t             pipe_q [3];
  ent_t             s1_ent;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [MW-1:0]    wr_data, rd_data;

  logic [DW-1:0]    q_dsq, g_dsq;
  logic             take, goal_hit;
  logic [DW-1:0]    best_d_q;
  logic [AW-1:0]    best_idx_q;
  logic [CW-1:0]    best_x_q, best_y_q;
  logic [IDX_W-1:0] best_p_q;
  logic             best_goal_q;

  logic             accept, out_load;
  logic             out_valid_q;
  out_item_t        out_data_q, out_data_d;

  logic [CW-1:0]    in_x, in_y;
  logic [CMP_W-1:0] vi_cmp, cnt_cmp;
  logic             scan_last;
  logic             pipe_busy, seq_quiet;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q      <= '0;
      goal_y_q      <= '0;
      goal_radius_q <= GOAL_RADIUS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GOAL_X:      goal_x_q      <= CW'(cfg_data_i[POS_W-1:0]);
        CFG_GOAL_Y:      goal_y_q      <= CW'(cfg_data_i[POS_W-1:0]);
        CFG_GOAL_RADIUS: goal_radius_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r_sq_q <= RSQ_W'(goal_radius_q) * RSQ_W'(goal_radius_q);
  end

  // Command sequencer
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_x       = CW'(in_data_i.pos_x);
  assign in_y       = CW'(in_data_i.pos_y);
  assign vi_cmp     = CMP_W'(in_data_i.vertex_index);
  assign cnt_cmp    = CMP_W'(count_q);
  assign scan_last  = (CNT_W'(scan_ptr_q) + CNT_W'(1)) == count_q;
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_ptr_d = scan_ptr_q;
    q_x_d      = q_x_q;
    q_y_d      = q_y_q;
    sts_d      = sts_q;
    dist_en_d  = dist_en_q;
    iss        = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          sts_d     = STS_OK;
          dist_en_d = 1'b0;
          case (in_data_i.command)
            CMD_ROOT: begin
              wr_en      = 1'b1;
              wr_data    = {in_x, in_y, IDX_W'(0)};
              count_d    = CNT_W'(1);
              iss        = '{valid: 1'b1, first: 1'b1, last: 1'b1, direct: 1'b1,
                             idx: '0, x: in_x, y: in_y, parent: '0};
              state_d    = S_DRAIN;
            end
            CMD_NEAREST: begin
              if (count_q == '0) begin
                sts_d   = STS_EMPTY;
                state_d = S_RESP;
              end else begin
                q_x_d      = in_x;
                q_y_d      = in_y;
                dist_en_d  = 1'b1;
                scan_ptr_d = '0;
                state_d    = S_SCAN;
              end
            end
            CMD_ADD: begin
              if (count_q == '0) begin
                sts_d   = STS_EMPTY;
                state_d = S_RESP;
              end else if (count_q == CNT_W'(MAX_VERTICES)) begin
                sts_d   = STS_FULL;
                state_d = S_RESP;
              end else if (vi_cmp >= cnt_cmp) begin
                sts_d   = STS_UNWRITTEN;
                state_d = S_RESP;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(count_q);
                wr_data = {in_x, in_y, in_data_i.vertex_index};
                count_d = count_q + CNT_W'(1);
                iss     = '{valid: 1'b1, first: 1'b1, last: 1'b1, direct: 1'b1,
                            idx: AW'(count_q), x: in_x, y: in_y,
                            parent: in_data_i.vertex_index};
                state_d = S_DRAIN;
              end
            end
            default: begin
              if (count_q == '0) begin
                sts_d   = STS_EMPTY;
                state_d = S_RESP;
              end else if (vi_cmp >= cnt_cmp) begin
                sts_d   = STS_UNWRITTEN;
                state_d = S_RESP;
              end else begin
                rd_en   = 1'b1;
                rd_addr = AW'(in_data_i.vertex_index);
                iss     = '{valid: 1'b1, first: 1'b1, last: 1'b1, direct: 1'b0,
                            idx: AW'(in_data_i.vertex_index), x: '0, y: '0,
                            parent: '0};
                state_d = S_DRAIN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_ptr_q;
        iss     = '{valid: 1'b1, first: (scan_ptr_q == '0), last: scan_last,
                    direct: 1'b0, idx: scan_ptr_q, x: '0, y: '0, parent: '0};
        if (scan_last) begin
          state_d = S_DRAIN;
        end else begin
          scan_ptr_d = scan_ptr_q + AW'(1);
        end
      end
      S_DRAIN: begin
        if (pipe_q[2].valid && pipe_q[2].last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      sts_q     <= STS_OK;
      dist_en_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sts_q     <= sts_d;
      dist_en_q <= dist_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_ptr_q <= scan_ptr_d;
    q_x_q      <= q_x_d;
    q_y_q      <= q_y_d;
  end

  // Vertex memory
  rrtnv_store #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW),
    .DW    (MW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Entry pipeline
  always_comb begin
    s1_ent.valid  = s1_q.valid;
    s1_ent.first  = s1_q.first;
    s1_ent.last   = s1_q.last;
    s1_ent.idx    = s1_q.idx;
    s1_ent.x      = s1_q.direct ? s1_q.x      : rd_data[MW-1 -: CW];
    s1_ent.y      = s1_q.direct ? s1_q.y      : rd_data[IDX_W+CW-1 -: CW];
    s1_ent.parent = s1_q.direct ? s1_q.parent : rd_data[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      pipe_q[0] <= '0;
      pipe_q[1] <= '0;
      pipe_q[2] <= '0;
    end else begin
      s1_q      <= iss;
      pipe_q[0] <= s1_ent;
      pipe_q[1] <= pipe_q[0];
      pipe_q[2] <= pipe_q[1];
    end
  end

  rrtnv_dist #(
    .CW (CW)
  ) u_dist_query (
    .clk_i     (clk_i),
    .a_x_i     (s1_ent.x),
    .a_y_i     (s1_ent.y),
    .b_x_i     (q_x_q),
    .b_y_i     (q_y_q),
    .dist_sq_o (q_dsq)
  );

  rrtnv_dist #(
    .CW (CW)
  ) u_dist_goal (
    .clk_i     (clk_i),
    .a_x_i     (s1_ent.x),
    .a_y_i     (s1_ent.y),
    .b_x_i     (goal_x_q),
    .b_y_i     (goal_y_q),
    .dist_sq_o (g_dsq)
  );

  // Best candidate
  assign take     = pipe_q[2].valid && (pipe_q[2].first || (q_dsq < best_d_q));
  assign goal_hit = GW'(g_dsq) <= GW'(r_sq_q);

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_d_q    <= q_dsq;
      best_idx_q  <= pipe_q[2].idx;
      best_x_q    <= pipe_q[2].x;
      best_y_q    <= pipe_q[2].y;
      best_p_q    <= pipe_q[2].parent;
      best_goal_q <= goal_hit;
    end
  end

  // Output register
  always_comb begin
    out_data_d = '0;
    out_data_d.status = sts_q;
    if (sts_q == STS_OK) begin
      out_data_d.result_index = IDX_W'(best_idx_q);
      out_data_d.vertex_x     = POS_W'(best_x_q);
      out_data_d.vertex_y     = POS_W'(best_y_q);
      out_data_d.has_parent   = (best_idx_q != '0);
      out_data_d.parent_index = (best_idx_q != '0) ? best_p_q : '0;
      out_data_d.distance_sq  = dist_en_q ? DSQ_W'(best_d_q) : '0;
      out_data_d.goal_reached = best_goal_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign pipe_busy = s1_q.valid || pipe_q[0].valid || pipe_q[1].valid || pipe_q[2].valid;
  assign seq_quiet = (state_q == S_IDLE) || (state_q == S_RESP);

  `RRT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(MAX_VERTICES), "count over capacity")
  `RRT_ASSERT_IMPL(a_pipe_idle, clk_i, rst_ni, seq_quiet, !pipe_busy, "pipeline busy while idle")
  `RRT_ASSERT_IMPL(a_scan_nonempty, clk_i, rst_ni, state_q == S_SCAN, count_q != '0, "empty scan")
  `RRT_ASSERT(a_out_from_resp, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_RESP), "stray result")

endmodule
